@@ design/zpdp_pkg.sv @@
// Shared types and constants of the int8 zero-point dot-product unit.
// No dependencies; every other design file imports this package.
`default_nettype none

package zpdp_pkg;

    // Accumulator width; the accumulator wraps modulo 2^ACC_WIDTH (range 20 to 48).
    localparam int ACC_WIDTH   = 32;
    localparam int OPND_WIDTH  = 8;
    localparam int DIFF_WIDTH  = OPND_WIDTH + 1;
    localparam int TERM_WIDTH  = 2 * DIFF_WIDTH;
    localparam int MULT_WIDTH  = 16;
    localparam int SHIFT_WIDTH = 6;
    localparam int RAW_WIDTH   = 32;
    localparam int SCL_WIDTH   = 48;
    localparam int WIDE_WIDTH  = 64;
    localparam int PROD_WIDTH  = ACC_WIDTH + MULT_WIDTH + 1;

    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    localparam int IN_TDATA_WIDTH  = 16;
    localparam int OUT_TDATA_WIDTH = 80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ZERO_POINT_A     = 2'd0,
        CFG_ZERO_POINT_B     = 2'd1,
        CFG_SCALE_MULTIPLIER = 2'd2,
        CFG_SCALE_SHIFT      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [OPND_WIDTH-1:0]  zero_point_a;
        logic signed [OPND_WIDTH-1:0]  zero_point_b;
        logic        [MULT_WIDTH-1:0]  scale_multiplier;
        logic        [SHIFT_WIDTH-1:0] scale_shift;
    } t_cfg;

    // One zero-point corrected product on its way to the accumulator.
    typedef struct packed {
        logic signed [TERM_WIDTH-1:0] product;
        logic                         last;
    } t_term;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

@@ design/zpdp_front.sv @@
// Front part: takes operand requests, removes zero points and forms the product.
// Depends on zpdp_pkg.
`default_nettype none

module zpdp_front (
    input  wire                                     i_rst_n,
    input  zpdp_pkg::t_cfg                          i_cfg,
    input  wire                                     i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire  [zpdp_pkg::IN_TDATA_WIDTH-1:0]     i_s_tdata,
    input  wire                                     i_s_tlast,
    input  zpdp_pkg::t_q_status                     i_q_status,
    output logic                                    o_push,
    output zpdp_pkg::t_term                         o_term
);
    import zpdp_pkg::*;

    logic signed [OPND_WIDTH-1:0] a_value;
    logic signed [OPND_WIDTH-1:0] b_value;
    logic signed [DIFF_WIDTH-1:0] diff_a;
    logic signed [DIFF_WIDTH-1:0] diff_b;

    assign a_value = signed'(i_s_tdata[OPND_WIDTH-1:0]);
    assign b_value = signed'(i_s_tdata[2*OPND_WIDTH-1:OPND_WIDTH]);

    // Nine bits hold any difference of two int8 values.
    assign diff_a = DIFF_WIDTH'(a_value) - DIFF_WIDTH'(i_cfg.zero_point_a);
    assign diff_b = DIFF_WIDTH'(b_value) - DIFF_WIDTH'(i_cfg.zero_point_b);

    assign o_s_tready     = i_rst_n && !i_q_status.full;
    assign o_push         = i_s_tvalid && o_s_tready;
    assign o_term.product = TERM_WIDTH'(diff_a) * TERM_WIDTH'(diff_b);
    assign o_term.last    = i_s_tlast;

endmodule

`default_nettype wire

@@ design/zpdp_fifo.sv @@
// Short queue of products between the front and the back part.
// Depends on zpdp_pkg.
`default_nettype none

module zpdp_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  zpdp_pkg::t_term      i_term,
    input  wire                  i_pop,
    output zpdp_pkg::t_term      o_term,
    output zpdp_pkg::t_q_status  o_status
);
    import zpdp_pkg::*;

    t_term                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;

    assign o_status.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_term         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/zpdp_back.sv @@
// Back part: accumulates products and, on the last term, scales and rounds the sum.
// Depends on zpdp_pkg.
`default_nettype none

module zpdp_back (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  zpdp_pkg::t_cfg                          i_cfg,
    input  zpdp_pkg::t_q_status                     i_q_status,
    input  zpdp_pkg::t_term                         i_term,
    output logic                                    o_pop,
    output logic                                    o_m_tvalid,
    input  wire                                     i_m_tready,
    output logic [zpdp_pkg::OUT_TDATA_WIDTH-1:0]    o_m_tdata
);
    import zpdp_pkg::*;

    localparam logic signed [SCL_WIDTH-1:0] SCL_MAX = {1'b0, {(SCL_WIDTH-1){1'b1}}};
    localparam logic signed [SCL_WIDTH-1:0] SCL_MIN = {1'b1, {(SCL_WIDTH-1){1'b0}}};

    logic                         advance;
    logic signed [ACC_WIDTH-1:0]  acc_sum;
    logic signed [MULT_WIDTH:0]   mult_s;
    logic signed [WIDE_WIDTH-1:0] wide_prod;
    logic signed [WIDE_WIDTH-1:0] shifted;
    logic                         round_bit;
    logic signed [WIDE_WIDTH-1:0] rounded;
    logic signed [SCL_WIDTH-1:0]  n_scaled;

    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic                         r_s1_valid;
    logic signed [ACC_WIDTH-1:0]  r_s1_sum;
    logic                         r_s2_valid;
    logic signed [ACC_WIDTH-1:0]  r_s2_sum;
    logic signed [PROD_WIDTH-1:0] r_s2_prod;
    logic                         r_out_valid;
    logic signed [RAW_WIDTH-1:0]  r_out_raw;
    logic signed [SCL_WIDTH-1:0]  r_out_scaled;

    // The whole result pipeline moves together whenever the output slot frees up.
    assign advance = !r_out_valid || i_m_tready;
    assign o_pop   = advance && !i_q_status.empty;
    assign acc_sum = r_acc + ACC_WIDTH'(i_term.product);
    assign mult_s  = signed'({1'b0, i_cfg.scale_multiplier});

    // Round to nearest with ties toward plus infinity, then clamp to 48 bits.
    always_comb begin
        wide_prod = WIDE_WIDTH'(r_s2_prod);
        shifted   = wide_prod >>> i_cfg.scale_shift;
        round_bit = 1'b0;
        if (i_cfg.scale_shift != '0) begin
            round_bit = wide_prod[i_cfg.scale_shift - SHIFT_WIDTH'(1)];
        end
        rounded = shifted + WIDE_WIDTH'(round_bit);
        if (&rounded[WIDE_WIDTH-1:SCL_WIDTH-1] || !(|rounded[WIDE_WIDTH-1:SCL_WIDTH-1])) begin
            n_scaled = rounded[SCL_WIDTH-1:0];
        end else if (rounded[WIDE_WIDTH-1]) begin
            n_scaled = SCL_MIN;
        end else begin
            n_scaled = SCL_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_pop && i_term.last;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
            if (o_pop) begin
                r_acc <= i_term.last ? '0 : acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_sum     <= acc_sum;
            r_s2_sum     <= r_s1_sum;
            r_s2_prod    <= r_s1_sum * mult_s;
            r_out_raw    <= RAW_WIDTH'(r_s2_sum);
            r_out_scaled <= n_scaled;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_scaled, r_out_raw};

endmodule

`default_nettype wire

@@ design/int8_zero_point_dot_product_unit.sv @@
// Top level of the int8 zero-point dot-product unit: configuration registers,
// front part, product queue and back part. Depends on zpdp_pkg and the zpdp_* modules.
//
//  Channel   Direction  Signals                          Contents
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  a_value, b_value; tlast = last_term
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  sum_raw, sum_scaled
//  cfg       in         i_cfg_we/i_cfg_idx/i_cfg_data    zero points, scale multiplier, shift
//
// One operand pair is taken per cycle while the four-entry queue has room.
// The accumulator takes one queued product per cycle while the output is not stalled;
// each accepted request is registered in the queue first. A popped last term passes
// the stage-1 sum register, the multiply stage and the round-and-output stage before
// it shows on o_m_tvalid. A stall on the output halts the result pipeline and the
// accumulator together, and the queue then fills and drops o_s_tready. Reset is
// synchronous and active low; it clears the accumulator and all valid flags.
`default_nettype none

module int8_zero_point_dot_product_unit (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_cfg_we,
    input  wire  [zpdp_pkg::CFG_IDX_WIDTH-1:0]         i_cfg_idx,
    input  wire  [zpdp_pkg::CFG_DATA_WIDTH-1:0]        i_cfg_data,
    input  wire                                        i_s_tvalid,
    output logic                                       o_s_tready,
    // [7:0] a_value, [15:8] b_value
    input  wire  [zpdp_pkg::IN_TDATA_WIDTH-1:0]        i_s_tdata,
    input  wire                                        i_s_tlast,
    output logic                                       o_m_tvalid,
    input  wire                                        i_m_tready,
    // [31:0] sum_raw, [79:32] sum_scaled
    output logic [zpdp_pkg::OUT_TDATA_WIDTH-1:0]       o_m_tdata
);
    import zpdp_pkg::*;

    t_cfg      r_cfg;
    t_term     push_term;
    t_term     pop_term;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_point_a     <= '0;
            r_cfg.zero_point_b     <= '0;
            r_cfg.scale_multiplier <= MULT_WIDTH'(1);
            r_cfg.scale_shift      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ZERO_POINT_A: begin
                    r_cfg.zero_point_a <= i_cfg_data[OPND_WIDTH-1:0];
                end
                CFG_ZERO_POINT_B: begin
                    r_cfg.zero_point_b <= i_cfg_data[OPND_WIDTH-1:0];
                end
                CFG_SCALE_MULTIPLIER: begin
                    r_cfg.scale_multiplier <= i_cfg_data[MULT_WIDTH-1:0];
                end
                CFG_SCALE_SHIFT: begin
                    r_cfg.scale_shift <= i_cfg_data[SHIFT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    zpdp_front u_front (
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_term     (push_term)
    );

    zpdp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_term   (push_term),
        .i_pop    (q_pop),
        .o_term   (pop_term),
        .o_status (q_status)
    );

    zpdp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_term     (pop_term),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("product queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("product queue read while empty");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered right after reset");

    a_pop_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !q_pop)
        else $error("queue drained while the output is stalled");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for int8_zero_point_dot_product_unit: streams operand pairs,
// predicts every dot-product result and checks the output stream against it.
// Depends on zpdp_pkg and the design files; needs nothing else.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zpdp_pkg::*;

    localparam int     QUIET_LIMIT     = 3000;
    localparam int     SETTLE_CYCLES   = 16;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     BURST_PAIRS     = 120;
    // Full-size terms of one sign in a single dot product.
    localparam int     RUN_TERMS       = 48;
    localparam longint SCALED_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SCALED_MIN      = -SCALED_MAX - 1;

    typedef struct {
        logic [RAW_WIDTH-1:0] raw;
        logic [SCL_WIDTH-1:0] scaled;
    } t_dot_result;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_cfg_we   = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data = '0;
    logic                       i_s_tvalid = 1'b0;
    logic                       o_s_tready;
    // [7:0] a_value, [15:8] b_value
    logic [IN_TDATA_WIDTH-1:0]  i_s_tdata  = '0;
    logic                       i_s_tlast  = 1'b0;
    logic                       o_m_tvalid;
    logic                       i_m_tready = 1'b0;
    // [31:0] sum_raw, [79:32] sum_scaled
    logic [OUT_TDATA_WIDTH-1:0] o_m_tdata;

    // Copy of the block's registers and accumulator, kept in step with accepted requests.
    logic signed [OPND_WIDTH-1:0]  cfg_zp_a  = '0;
    logic signed [OPND_WIDTH-1:0]  cfg_zp_b  = '0;
    logic        [MULT_WIDTH-1:0]  cfg_mult  = 16'd1;
    logic        [SHIFT_WIDTH-1:0] cfg_shift = '0;
    logic        [ACC_WIDTH-1:0]   acc_sum   = '0;

    t_dot_result expected_sums[$];
    t_dot_result seen_sum;
    t_dot_result want_sum;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int pairs_sent     = 0;
    int sums_checked   = 0;
    int reg_writes     = 0;

    int8_zero_point_dot_product_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Accumulates one corrected product and, on the last term, queues the expected sums.
    function automatic void accumulate_pair(input logic signed [7:0] a,
                                            input logic signed [7:0] b,
                                            input logic last);
        int          diff_a;
        int          diff_b;
        longint      term;
        longint      sum;
        longint      prod;
        longint      rounded;
        t_dot_result res;
        diff_a  = int'(a) - int'(cfg_zp_a);
        diff_b  = int'(b) - int'(cfg_zp_b);
        term    = longint'(diff_a * diff_b);
        acc_sum = acc_sum + term[ACC_WIDTH-1:0];
        if (last) begin
            sum     = longint'($signed(acc_sum));
            prod    = sum * longint'(cfg_mult);
            rounded = prod >>> cfg_shift;
            // Round half up: add the last bit shifted out.
            if (cfg_shift != 0 && prod[cfg_shift - 1])
                rounded++;
            if (rounded > SCALED_MAX)
                rounded = SCALED_MAX;
            if (rounded < SCALED_MIN)
                rounded = SCALED_MIN;
            res.raw    = sum[RAW_WIDTH-1:0];
            res.scaled = rounded[SCL_WIDTH-1:0];
            expected_sums.push_back(res);
            acc_sum = '0;
        end
    endfunction

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(19))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Sends one operand pair; valid stays high afterwards unless the next request idles.
    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tlast  <= last;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        accumulate_pair(a, b, last);
        pairs_sent++;
    endtask

    // Stops the sender, waits for every expected sum and lets queued terms settle.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_sums.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_register(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_ZERO_POINT_A:     cfg_zp_a  = value[7:0];
            CFG_ZERO_POINT_B:     cfg_zp_b  = value[7:0];
            CFG_SCALE_MULTIPLIER: cfg_mult  = value;
            CFG_SCALE_SHIFT:      cfg_shift = value[5:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_config(input logic [7:0] zp_a, input logic [7:0] zp_b,
                                input logic [15:0] mult, input logic [5:0] shift);
        put_register(CFG_ZERO_POINT_A, {8'h00, zp_a});
        put_register(CFG_ZERO_POINT_B, {8'h00, zp_b});
        put_register(CFG_SCALE_MULTIPLIER, mult);
        put_register(CFG_SCALE_SHIFT, {10'h000, shift});
        i_cfg_we <= 1'b0;
    endtask

    task automatic randomize_config();
        logic [15:0] mult;
        logic [5:0]  shift;
        case ($urandom_range(9))
            0: mult = 16'h0000;
            1: mult = 16'hFFFF;
            2: mult = 16'h0001;
            default: mult = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0: shift = 6'($urandom_range(48, 63));
            1: shift = 6'd47;
            2: shift = 6'd0;
            default: shift = 6'($urandom_range(1, 24));
        endcase
        write_config(pick_operand(), pick_operand(), mult, shift);
    endtask

    // Registers still hold their reset values here.
    task automatic test_reset_defaults();
        send_pair(8'h7F, 8'h7F, 1'b1);
        send_pair(8'h80, 8'h80, 1'b1);
        send_pair(8'h80, 8'h7F, 1'b1);
        send_pair(8'h00, 8'h00, 1'b1);
        send_pair(8'h05, 8'hF9, 1'b0);
        send_pair(8'h64, 8'h03, 1'b0);
        send_pair(8'h80, 8'hFF, 1'b1);
    endtask

    task automatic test_extreme_scaling();
        // Widest corrected operands, full multiplier, no shift.
        wait_drained();
        write_config(8'h80, 8'h7F, 16'hFFFF, 6'd0);
        send_pair(8'h7F, 8'h80, 1'b1);
        send_pair(8'h80, 8'h7F, 1'b1);
        send_pair(8'h7F, 8'h7F, 1'b0);
        send_pair(8'h7F, 8'h00, 1'b1);
        // Largest documented shift, then shifts past it, which are applied as given.
        wait_drained();
        write_config(8'h7F, 8'h80, 16'hFFFF, 6'd47);
        send_pair(8'h80, 8'h7F, 1'b1);
        wait_drained();
        write_config(8'h7F, 8'h80, 16'hFFFF, 6'd63);
        send_pair(8'h80, 8'h7F, 1'b1);
        send_pair(8'h7F, 8'h80, 1'b1);
        // Halfway cases round toward plus infinity.
        wait_drained();
        write_config(8'h00, 8'h00, 16'h0001, 6'd1);
        send_pair(8'h03, 8'hFF, 1'b1);
        send_pair(8'h01, 8'h01, 1'b1);
        send_pair(8'hFF, 8'h01, 1'b1);
        // A zero multiplier clears the scaled sum but not the raw one.
        wait_drained();
        write_config(8'h01, 8'hFF, 16'h0000, 6'd5);
        send_pair(8'h7F, 8'h7F, 1'b1);
    endtask

    task automatic test_long_runs();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_config(8'h80, 8'h80, 16'hFFFF, 6'd16);
        for (int k = 0; k < RUN_TERMS; k++)
            send_pair(8'h7F, 8'h7F, k == RUN_TERMS - 1);
        wait_drained();
        write_config(8'h80, 8'h7F, 16'h8001, 6'd3);
        for (int k = 0; k < RUN_TERMS; k++)
            send_pair(8'h7F, 8'h80, k == RUN_TERMS - 1);
    endtask

    // The output holds off long enough for the product queue to fill and stall the input.
    task automatic test_output_hold_off();
        wait_drained();
        write_config(8'h03, 8'hFE, 16'd300, 6'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = HOLD_OFF_CYCLES;
        for (int k = 0; k < 48; k++)
            send_pair(pick_operand(), pick_operand(), k[0]);
        wait_drained();
        recv_stall_pct = 50;
        for (int k = 0; k < 30; k++)
            send_pair(pick_operand(), pick_operand(), k % 3 == 2);
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input int pairs);
        int sent;
        int burst;
        int len;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < pairs) begin
            wait_drained();
            randomize_config();
            burst = 0;
            while (burst < BURST_PAIRS && sent < pairs) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_pair(pick_operand(), pick_operand(), k == len - 1);
                burst += len;
                sent  += len;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_sum.raw    = o_m_tdata[31:0];
            seen_sum.scaled = o_m_tdata[79:32];
            if (expected_sums.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result raw %0d scaled %0d", $time,
                         $signed(seen_sum.raw), $signed(seen_sum.scaled));
            end else begin
                want_sum = expected_sums.pop_front();
                sums_checked++;
                if (seen_sum.raw !== want_sum.raw) begin
                    error_count++;
                    $display("%0t: sum_raw expected %0d actual %0d", $time,
                             $signed(want_sum.raw), $signed(seen_sum.raw));
                end
                if (seen_sum.scaled !== want_sum.scaled) begin
                    error_count++;
                    $display("%0t: sum_scaled expected %0d actual %0d", $time,
                             $signed(want_sum.scaled), $signed(seen_sum.scaled));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_extreme_scaling();
        test_long_runs();
        test_output_hold_off();
        test_random_traffic(0, 0, 420);
        test_random_traffic(81, 0, 420);
        test_random_traffic(0, 81, 420);
        test_random_traffic(14, 14, 420);
        wait_drained();
        if (expected_sums.size() != 0)
            error_count++;
        $display("Run covered %0d operand pairs, %0d dot products, %0d register writes,",
                 pairs_sent, sums_checked, reg_writes);
        $display("with long same-sign runs, rounding ties, shifts past 47 and a long output stall.");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
